### src/dfpe_pkg.sv
// ----------------------------------------------------------------------------
// dfpe_pkg
// Shared codes, types and helpers for the display frame protocol engine.
// ----------------------------------------------------------------------------
package dfpe_pkg;

    // framing bytes
    localparam logic [7:0] ACK_BYTE   = 8'h06;
    localparam logic [7:0] DC1_BYTE   = 8'h11;
    localparam logic [7:0] DC2_BYTE   = 8'h12;
    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] ONE_BYTE   = 8'h01;
    localparam logic [7:0] REQ_S_BYTE = 8'h53;

    // sum of DC1, ESC and the one added to the length byte; the payload length adds on top
    localparam logic [7:0] WR_HDR_SUM = 8'h2D;
    // sum of the fixed read request 12 01 53
    localparam logic [7:0] RD_REQ_SUM = 8'h66;

    // host commands
    localparam logic [1:0] CMD_START_WRITE = 2'd0;
    localparam logic [1:0] CMD_WRITE_BYTE  = 2'd1;
    localparam logic [1:0] CMD_START_READ  = 2'd2;
    localparam logic [1:0] CMD_RX_BYTE     = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // protocol phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_W_PAYLOAD = 4'd1;
    localparam logic [3:0] PH_W_ACK     = 4'd2;
    localparam logic [3:0] PH_R_ACK     = 4'd3;
    localparam logic [3:0] PH_R_DC1     = 4'd4;
    localparam logic [3:0] PH_R_LEN     = 4'd5;
    localparam logic [3:0] PH_R_DATA    = 4'd6;
    localparam logic [3:0] PH_R_SUM     = 4'd7;

    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       err;
    } t_res;

    // all words caused by one input item
    typedef struct packed {
        logic [2:0]             cnt;
        t_res [MAX_RES-1:0]     res;
    } t_batch;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [7:0] data,
                                    input logic err);
        t_res r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        return r;
    endfunction

endpackage

### src/dfpe_core.sv
// ----------------------------------------------------------------------------
// dfpe_core
// Protocol state and per-item framing/deframing logic. Produces the full
// batch of result words for the item presented on the input.
// ----------------------------------------------------------------------------
module dfpe_core import dfpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_plen,
    input  logic       i_has,
    output t_batch     o_batch
);

    logic [3:0] r_phase, n_phase;
    logic [7:0] r_sum,   n_sum;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_count, n_count;

    logic       bad;
    logic [7:0] sum_b;
    logic [7:0] count_inc;
    t_batch     batch;

    assign sum_b     = r_sum + i_byte;
    assign count_inc = r_count + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_len   = r_len;
        n_count = r_count;
        bad     = 1'b0;
        batch   = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_cmd == CMD_START_WRITE) begin
                    batch.res[0] = mk_res(KIND_TX, DC1_BYTE, 1'b0);
                    batch.res[1] = mk_res(KIND_TX, i_plen + 8'd1, 1'b0);
                    batch.res[2] = mk_res(KIND_TX, ESC_BYTE, 1'b0);
                    n_sum   = i_plen + WR_HDR_SUM;
                    n_len   = i_plen;
                    n_count = '0;
                    if (i_plen == 8'd0) begin
                        batch.res[3] = mk_res(KIND_TX, WR_HDR_SUM, 1'b0);
                        batch.cnt    = 3'd4;
                        n_phase      = PH_W_ACK;
                    end else begin
                        batch.cnt = 3'd3;
                        n_phase   = PH_W_PAYLOAD;
                    end
                end else if (i_cmd == CMD_START_READ) begin
                    if (!i_has) begin
                        bad = 1'b1;
                    end else begin
                        batch.res[0] = mk_res(KIND_TX, DC2_BYTE, 1'b0);
                        batch.res[1] = mk_res(KIND_TX, ONE_BYTE, 1'b0);
                        batch.res[2] = mk_res(KIND_TX, REQ_S_BYTE, 1'b0);
                        batch.res[3] = mk_res(KIND_TX, RD_REQ_SUM, 1'b0);
                        batch.cnt    = 3'd4;
                        n_sum        = RD_REQ_SUM;
                        n_phase      = PH_R_ACK;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            PH_W_PAYLOAD: begin
                if (i_cmd == CMD_WRITE_BYTE) begin
                    batch.res[0] = mk_res(KIND_TX, i_byte, 1'b0);
                    n_sum   = sum_b;
                    n_count = count_inc;
                    if (count_inc == r_len) begin
                        batch.res[1] = mk_res(KIND_TX, sum_b, 1'b0);
                        batch.cnt    = 3'd2;
                        n_phase      = PH_W_ACK;
                    end else begin
                        batch.cnt = 3'd1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            PH_W_ACK: begin
                if (i_cmd == CMD_RX_BYTE) begin
                    batch.res[0] = mk_res(KIND_STATUS, 8'd0, i_byte != ACK_BYTE);
                    batch.cnt    = 3'd1;
                    n_phase      = PH_IDLE;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_R_ACK: begin
                if (i_cmd == CMD_RX_BYTE && i_byte == ACK_BYTE) begin
                    n_sum   = '0;
                    n_phase = PH_R_DC1;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_R_DC1: begin
                if (i_cmd == CMD_RX_BYTE) begin
                    n_sum = sum_b;
                    if (i_byte == DC1_BYTE) begin
                        n_phase = PH_R_LEN;
                    end else begin
                        bad = 1'b1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            PH_R_LEN: begin
                if (i_cmd == CMD_RX_BYTE) begin
                    n_sum   = sum_b;
                    n_len   = i_byte;
                    n_count = '0;
                    n_phase = (i_byte == 8'd0) ? PH_R_SUM : PH_R_DATA;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_R_DATA: begin
                if (i_cmd == CMD_RX_BYTE) begin
                    batch.res[0] = mk_res(KIND_DATA, i_byte, 1'b0);
                    batch.cnt    = 3'd1;
                    n_sum        = sum_b;
                    n_count      = count_inc;
                    if (count_inc == r_len) begin
                        n_phase = PH_R_SUM;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            PH_R_SUM: begin
                if (i_cmd == CMD_RX_BYTE) begin
                    if (i_byte == r_sum) begin
                        batch.res[0] = mk_res(KIND_STATUS, r_len, 1'b0);
                    end else begin
                        batch.res[0] = mk_res(KIND_STATUS, 8'd0, 1'b1);
                    end
                    batch.cnt = 3'd1;
                    n_phase   = PH_IDLE;
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        // unexpected item: single error status, back to idle
        if (bad) begin
            batch.res    = '0;
            batch.res[0] = mk_res(KIND_STATUS, 8'd0, 1'b1);
            batch.cnt    = 3'd1;
            n_phase      = PH_IDLE;
        end
    end

    assign o_batch = batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= '0;
            r_len   <= '0;
            r_count <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

    a_phase_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_R_SUM)
        else $error("phase register left the defined range");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && batch.res[0].kind == KIND_STATUS |=> r_phase == PH_IDLE)
        else $error("status emitted without returning to idle");

endmodule

### src/dfpe_ser.sv
// ----------------------------------------------------------------------------
// dfpe_ser
// Result register bank: holds the words of one item and hands them out one
// word per cycle while the receiver is ready. Takes the next batch as the last word leaves.
// ----------------------------------------------------------------------------
module dfpe_ser import dfpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_batch     i_batch,
    input  logic       i_m_tready,
    output logic       o_room,
    output logic       o_m_tvalid,
    output t_res       o_word,
    output logic       o_m_tlast
);

    t_res [MAX_RES-1:0] r_buf;
    logic [2:0]         r_cnt, n_cnt;
    logic [1:0]         r_idx, n_idx;

    logic last_word;
    logic take;

    assign o_m_tvalid = (r_cnt != 3'd0);
    assign last_word  = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign take       = o_m_tvalid && i_m_tready;
    assign o_room     = !o_m_tvalid || (take && last_word);
    assign o_word     = r_buf[r_idx];
    assign o_m_tlast  = last_word;

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_load) begin
            n_cnt = i_batch.cnt;
            n_idx = '0;
        end else if (take) begin
            if (last_word) begin
                n_cnt = '0;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_batch.res;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("word count out of range");

    a_idx_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, r_idx} < r_cnt))
        else $error("read index beyond loaded words");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!o_m_tvalid || (take && last_word)))
        else $error("batch loaded over undelivered words");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(r_idx) && $stable(r_cnt))
        else $error("word position moved during stall");

endmodule

### src/display_frame_protocol_engine.sv
// ----------------------------------------------------------------------------
// display_frame_protocol_engine
// DC1/DC2 framed display link engine with 8-bit sum checksum.
// The first result word of an item is on the output the cycle after the
//   item is accepted; its words follow one per cycle while the receiver is ready.
// A new item is taken as the last word of the previous one leaves, or at once if the
//   bank is empty, so up to one item per cycle while the receiver is ready.
// Reset (i_rst_n low, synchronous): phase idle, sum/length/count cleared,
//   result bank emptied.
// ----------------------------------------------------------------------------
module display_frame_protocol_engine import dfpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] data_byte, [15:8] payload_length, [16] display_has_data, [23:17] zero
    input  logic [23:0] i_s_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] result_byte
    output logic [7:0]  o_m_tdata,
    // [1:0] result_kind, [2] error_flag
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    logic   room;
    logic   take_in;
    t_batch batch;
    t_res   word;

    assign o_s_tready = room;
    assign take_in    = i_s_tvalid && room;

    dfpe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take_in),
        .i_cmd   (i_s_tuser),
        .i_byte  (i_s_tdata[7:0]),
        .i_plen  (i_s_tdata[15:8]),
        .i_has   (i_s_tdata[16]),
        .o_batch (batch)
    );

    dfpe_ser u_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take_in),
        .i_batch    (batch),
        .i_m_tready (i_m_tready),
        .o_room     (room),
        .o_m_tvalid (o_m_tvalid),
        .o_word     (word),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_m_tdata = word.data;
    assign o_m_tuser = {word.err, word.kind};

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the display frame protocol engine. A behavioral model
// of the framer/deframer tracks phase, checksum and counts, predicts every
// output word for each accepted host item, and checks the output stream in
// order. Directed frames first, then random write/read exchanges with broken
// replies and noise, under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
import dfpe_pkg::*;

typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       err;
    logic       last;
} t_word;

class frame_tracker;
    logic [3:0] phase;
    logic [7:0] frame_sum;
    logic [7:0] frame_len;
    logic [7:0] byte_cnt;
    t_word      due_words[$];
    int         fails;
    int         words_seen;
    int         ok_status;
    int         err_status;
    int         rd_data;

    function new();
        phase      = PH_IDLE;
        frame_sum  = 8'd0;
        frame_len  = 8'd0;
        byte_cnt   = 8'd0;
        fails      = 0;
        words_seen = 0;
        ok_status  = 0;
        err_status = 0;
        rd_data    = 0;
    endfunction

    function void add_word(logic [1:0] kind, logic [7:0] data, logic err);
        t_word w;
        w.kind = kind;
        w.data = data;
        w.err  = err;
        w.last = 1'b0;
        due_words.push_back(w);
    endfunction

    // transmitted framing/payload bytes feed the checksum
    function void emit_tx(logic [7:0] b);
        add_word(KIND_TX, b, 1'b0);
        frame_sum = frame_sum + b;
    endfunction

    function void end_frame(logic [7:0] b, logic err);
        add_word(KIND_STATUS, err ? 8'd0 : b, err);
        phase = PH_IDLE;
    endfunction

    function int outstanding();
        return due_words.size();
    endfunction

    function void take_item(logic [1:0] cmd, logic [7:0] b, logic [7:0] plen, logic has);
        int    before_n;
        t_word w;
        before_n = due_words.size();
        if (phase == PH_IDLE && cmd == CMD_START_WRITE) begin
            frame_sum = 8'd0;
            emit_tx(DC1_BYTE);
            emit_tx(plen + 8'd1);
            emit_tx(ESC_BYTE);
            frame_len = plen;
            byte_cnt  = 8'd0;
            if (plen == 8'd0) begin
                add_word(KIND_TX, frame_sum, 1'b0);
                phase = PH_W_ACK;
            end else begin
                phase = PH_W_PAYLOAD;
            end
        end else if (phase == PH_IDLE && cmd == CMD_START_READ) begin
            if (!has) begin
                end_frame(8'd0, 1'b1);
            end else begin
                frame_sum = 8'd0;
                emit_tx(DC2_BYTE);
                emit_tx(ONE_BYTE);
                emit_tx(REQ_S_BYTE);
                add_word(KIND_TX, frame_sum, 1'b0);
                phase = PH_R_ACK;
            end
        end else if (phase == PH_W_PAYLOAD && cmd == CMD_WRITE_BYTE) begin
            emit_tx(b);
            byte_cnt = byte_cnt + 8'd1;
            if (byte_cnt == frame_len) begin
                add_word(KIND_TX, frame_sum, 1'b0);
                phase = PH_W_ACK;
            end
        end else if (phase == PH_W_ACK && cmd == CMD_RX_BYTE) begin
            end_frame(8'd0, b != ACK_BYTE);
        end else if (phase == PH_R_ACK && cmd == CMD_RX_BYTE) begin
            if (b != ACK_BYTE) begin
                end_frame(8'd0, 1'b1);
            end else begin
                frame_sum = 8'd0;
                phase     = PH_R_DC1;
            end
        end else if (phase == PH_R_DC1 && cmd == CMD_RX_BYTE) begin
            frame_sum = frame_sum + b;
            if (b != DC1_BYTE)
                end_frame(8'd0, 1'b1);
            else
                phase = PH_R_LEN;
        end else if (phase == PH_R_LEN && cmd == CMD_RX_BYTE) begin
            frame_sum = frame_sum + b;
            frame_len = b;
            byte_cnt  = 8'd0;
            phase     = (b == 8'd0) ? PH_R_SUM : PH_R_DATA;
        end else if (phase == PH_R_DATA && cmd == CMD_RX_BYTE) begin
            add_word(KIND_DATA, b, 1'b0);
            frame_sum = frame_sum + b;
            byte_cnt  = byte_cnt + 8'd1;
            if (byte_cnt == frame_len)
                phase = PH_R_SUM;
        end else if (phase == PH_R_SUM && cmd == CMD_RX_BYTE) begin
            if (b == frame_sum)
                end_frame(frame_len, 1'b0);
            else
                end_frame(8'd0, 1'b1);
        end else begin
            // anything the phase does not expect
            end_frame(8'd0, 1'b1);
        end
        if (due_words.size() > before_n) begin
            w = due_words.pop_back();
            w.last = 1'b1;
            due_words.push_back(w);
        end
    endfunction

    function void match_word(time t, logic [1:0] kind, logic [7:0] data, logic err,
                             logic last);
        t_word e;
        words_seen++;
        if (due_words.size() == 0) begin
            fails++;
            $display("%0t: unexpected word, expected none, got kind %0d data %02h err %0d last %0d",
                     t, kind, data, err, last);
            return;
        end
        e = due_words.pop_front();
        if (e.kind !== kind || e.data !== data || e.err !== err || e.last !== last) begin
            fails++;
            $display("%0t: word mismatch, expected kind %0d data %02h err %0d last %0d,",
                     t, e.kind, e.data, e.err, e.last);
            $display("%0t:   got kind %0d data %02h err %0d last %0d",
                     t, kind, data, err, last);
        end
        if (kind == KIND_STATUS) begin
            if (err)
                err_status++;
            else
                ok_status++;
        end else if (kind == KIND_DATA) begin
            rd_data++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;
    localparam int END_WAIT    = 20;
    localparam int RAND_ITEMS  = 200;

    // receiver stall patterns
    localparam int RX_FREE   = 0;
    localparam int RX_HALF   = 1;
    localparam int RX_SLOW   = 2;
    localparam int RX_MOSTLY = 3;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = 24'd0;
    logic [1:0]  s_tuser  = 2'd0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    frame_tracker tracker = new();

    int stall_cycles = 0;
    int burst_left   = 0;
    int n_items      = 0;
    bit no_gaps      = 1'b0;
    bit hold_req     = 1'b0;
    bit wind_down    = 1'b0;

    display_frame_protocol_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // one host word; opens a new burst after a random gap when the last one ran out
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic [7:0] plen, input logic has);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, has, plen, b};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.take_item(cmd, b, plen, has);
        n_items++;
    endtask

    // sender idles until every predicted word has come out
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_exchange(input int plen, input bit may_break);
        int         i;
        logic [7:0] ack;
        send_item(CMD_START_WRITE, rnd_byte(), plen[7:0], rnd_bit());
        for (i = 0; i < plen; i++) begin
            if (may_break && $urandom_range(0, 39) == 0)
                return;
            send_item(CMD_WRITE_BYTE, rnd_byte(), rnd_byte(), rnd_bit());
        end
        ack = ($urandom_range(0, 7) == 0) ? rnd_byte() : ACK_BYTE;
        send_item(CMD_RX_BYTE, ack, rnd_byte(), rnd_bit());
    endtask

    // host read request plus the display reply; cut is the step after which it stops
    task automatic read_exchange(input bit may_break);
        int         len;
        int         i;
        int         cut;
        logic       has;
        logic [7:0] b;
        logic [7:0] sum;
        has = ($urandom_range(0, 9) != 0);
        send_item(CMD_START_READ, rnd_byte(), rnd_byte(), has);
        if (!has)
            return;
        cut = (may_break && $urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
        if (cut == 0)
            return;
        b = ($urandom_range(0, 15) == 0) ? rnd_byte() : ACK_BYTE;
        send_item(CMD_RX_BYTE, b, rnd_byte(), rnd_bit());
        if (b != ACK_BYTE || cut == 1)
            return;
        b = ($urandom_range(0, 15) == 0) ? rnd_byte() : DC1_BYTE;
        send_item(CMD_RX_BYTE, b, rnd_byte(), rnd_bit());
        if (b != DC1_BYTE || cut == 2)
            return;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
        sum = DC1_BYTE + len[7:0];
        send_item(CMD_RX_BYTE, len[7:0], rnd_byte(), rnd_bit());
        if (cut == 3)
            return;
        for (i = 0; i < len; i++) begin
            b   = rnd_byte();
            sum = sum + b;
            send_item(CMD_RX_BYTE, b, rnd_byte(), rnd_bit());
        end
        if ($urandom_range(0, 6) == 0)
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_item(CMD_RX_BYTE, sum, rnd_byte(), rnd_bit());
    endtask

    // receiver: random stall segments, plus one long hold-off on request
    initial begin
        int seg_left;
        int seg_mode;
        int hold_cnt;
        seg_left = 0;
        seg_mode = RX_FREE;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (wind_down) begin
                m_tready <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(RX_FREE, RX_MOSTLY);
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                case (seg_mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
                    RX_SLOW:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // output monitor and progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready)
            tracker.match_word($time, o_m_tuser[1:0], o_m_tdata, o_m_tuser[2], o_m_tlast);
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d words still due",
                         $time, STALL_LIMIT, tracker.outstanding());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int start_n;
        int pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty write, acked
        send_item(CMD_START_WRITE, 8'h00, 8'd0, 1'b0);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'hFF, 1'b1);
        // one-byte write, bad ack
        send_item(CMD_START_WRITE, 8'hFF, 8'd1, 1'b1);
        send_item(CMD_WRITE_BYTE, 8'hFF, 8'd0, 1'b0);
        send_item(CMD_RX_BYTE, 8'h15, 8'h00, 1'b0);
        // read with nothing buffered
        send_item(CMD_START_READ, 8'h00, 8'h00, 1'b0);
        // empty read reply
        send_item(CMD_START_READ, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, DC1_BYTE, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, 8'h00, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, DC1_BYTE, 8'h00, 1'b0);
        // wrong acknowledge
        send_item(CMD_START_READ, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, 8'h07, 8'h00, 1'b0);
        // wrong start byte
        send_item(CMD_START_READ, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, DC2_BYTE, 8'h00, 1'b0);
        // two data bytes, checksum off by one
        send_item(CMD_START_READ, 8'h00, 8'h00, 1'b1);
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, DC1_BYTE, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, 8'h02, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, 8'hAA, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, 8'h55, 8'h00, 1'b0);
        send_item(CMD_RX_BYTE, 8'h13, 8'h00, 1'b0);
        // out of sequence: rx while idle, start_write while busy
        send_item(CMD_RX_BYTE, ACK_BYTE, 8'h00, 1'b0);
        send_item(CMD_START_WRITE, 8'h00, 8'd3, 1'b0);
        send_item(CMD_START_WRITE, 8'h00, 8'd3, 1'b0);
        drain();

        // receiver holds off while the sender keeps pushing a frame
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        write_exchange(8, 1'b0);
        no_gaps  = 1'b0;
        drain();

        // longest write: length byte wraps to zero
        write_exchange(255, 1'b0);
        drain();

        start_n = n_items;
        while (n_items - start_n < RAND_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 9);
            if (pick < 4)
                write_exchange(($urandom_range(0, 9) == 0) ? $urandom_range(0, 254)
                                                           : $urandom_range(0, 6), 1'b1);
            else if (pick < 8)
                read_exchange(1'b1);
            else
                send_item(2'($urandom_range(0, 3)), rnd_byte(), rnd_byte(), rnd_bit());
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        wind_down = 1'b1;
        repeat (END_WAIT) @(posedge i_clk);

        $display("run covered %0d host words and %0d output words", n_items, tracker.words_seen);
        $display("statuses: %0d ok, %0d error; %0d read data bytes; %0d mismatches",
                 tracker.ok_status, tracker.err_status, tracker.rd_data, tracker.fails);
        if (tracker.outstanding() != 0)
            $display("%0t: %0d predicted words never came out", $time, tracker.outstanding());
        if (tracker.fails == 0 && tracker.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### filelist.f
src/dfpe_pkg.sv
src/dfpe_core.sv
src/dfpe_ser.sv
src/display_frame_protocol_engine.sv
sim/testbench.sv
